### rtl/assert_macros.svh
// Assertion macros shared by the RTL files.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, checked at every rising edge outside reset.
`define ASSERT_IMPL(lbl, clk, rst, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("Same-cycle check failed.");

// Next-cycle implication, checked at every rising edge outside reset.
`define ASSERT_NEXT(lbl, clk, rst, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("Next-cycle check failed.");

`endif

### rtl/sitar_pkg.sv
// Shared types, constants and the digit-to-character function.
package sitar_pkg;

  localparam int DIGIT_BITS    = 6;
  // Quotient bits produced by the divider in one cycle.
  localparam int BITS_PER_STEP = 4;

  localparam logic [DIGIT_BITS-1:0] RADIX_MIN   = 6'd2;
  localparam logic [DIGIT_BITS-1:0] RADIX_MAX   = 6'd36;
  localparam logic [DIGIT_BITS-1:0] RADIX_RESET = 6'd10;
  localparam logic [7:0]            MINUS_CHAR  = 8'h2D;
  localparam logic [7:0]            NUL_CHAR    = 8'h00;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic load;
    logic div_step;
    logic store;
    logic emit_sign;
    logic emit_digit;
    logic emit_nul;
  } cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic radix_ok;
    logic div_last;
    logic q_zero;
    logic neg;
    logic ptr_zero;
  } status_t;

  // Digits 0..9 map to '0'..'9', digits 10..35 to 'a'..'z'.
  function automatic logic [7:0] digit_char(input logic [DIGIT_BITS-1:0] d);
    logic [7:0] ext;
    ext = {2'b00, d};
    if (d < 6'd10) begin
      return 8'h30 + ext;
    end else begin
      return 8'h61 + ext - 8'd10;
    end
  endfunction

endpackage

### rtl/signed_int_to_text_any_radix_top.sv
// Top level: signed integer to text in radix 2..36, with the register port.
//
//   Channel   Ports                                    Handshake
//   input     start, busy, number                      taken when start && !busy
//   result    char_valid, text_char, is_last           one beat per cycle, no stall
//   config    psel, penable, pwrite, paddr, pwdata,    APB write, radix at 0x0
//             prdata, pready
//
// An item keeps busy high while the divider, which yields 4 quotient bits per cycle
// and one digit per pass, produces every digit, and while the digits are emitted.
// A bad radix gives only the terminator beat, in the cycle after start; busy stays low.
// Reset is synchronous and returns the radix to 10 and the controller to idle.
// The receiver cannot stall; each beat is valid for exactly one cycle.
`include "assert_macros.svh"

module signed_int_to_text_any_radix_top
  import sitar_pkg::*;
#(
  parameter int VALUE_BITS = 32
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         start,
  output logic                         busy,
  input  logic signed [VALUE_BITS-1:0] number,
  output logic [7:0]                   text_char,
  output logic                         is_last,
  output logic                         char_valid,
  input  logic                         psel,
  input  logic                         penable,
  input  logic                         pwrite,
  input  logic [2:0]                   paddr,
  input  logic [31:0]                  pwdata,
  output logic [31:0]                  prdata,
  output logic                         pready
);

  logic [DIGIT_BITS-1:0] radix;
  logic                  reg_sel;
  logic                  wr_en;
  cmd_t                  cmd;
  status_t               status;

  // Register port: one register, the radix, at byte address 0.
  assign pready  = 1'b1;
  assign reg_sel = (paddr[2] == 1'b0);
  assign wr_en   = psel && penable && pwrite && pready && reg_sel;
  assign prdata  = reg_sel ? {{(32 - DIGIT_BITS){1'b0}}, radix} : 32'h0;

  always_ff @(posedge clk) begin
    if (rst) begin
      radix <= RADIX_RESET;
    end else if (wr_en) begin
      radix <= pwdata[DIGIT_BITS-1:0];
    end
  end

  sitar_ctrl u_ctrl (
    .clk    (clk),
    .rst    (rst),
    .start  (start),
    .status (status),
    .cmd    (cmd),
    .busy   (busy)
  );

  sitar_datapath #(
    .VALUE_BITS (VALUE_BITS)
  ) u_datapath (
    .clk        (clk),
    .rst        (rst),
    .number     (number),
    .radix      (radix),
    .cmd        (cmd),
    .status     (status),
    .text_char  (text_char),
    .is_last    (is_last),
    .char_valid (char_valid)
  );

  // A bad radix answers with the terminator alone on the next cycle.
  `ASSERT_NEXT(a_bad_radix_nul, clk, rst, start && !busy && !status.radix_ok, char_valid && is_last && (text_char == NUL_CHAR))
  // A good radix starts a conversion.
  `ASSERT_NEXT(a_good_radix_busy, clk, rst, start && !busy && status.radix_ok, busy)
  // The terminator beat leaves the block ready for the next item.
  `ASSERT_IMPL(a_last_idle, clk, rst, char_valid && is_last, !busy)
  // Every other character beat comes while the conversion is still running.
  `ASSERT_IMPL(a_char_busy, clk, rst, char_valid && !is_last, busy)

endmodule

### rtl/sitar_ctrl.sv
// Controller state machine that sequences division, digit storage and output.
module sitar_ctrl
  import sitar_pkg::*;
(
  input  logic    clk,
  input  logic    rst,
  input  logic    start,
  input  status_t status,
  output cmd_t    cmd,
  output logic    busy
);

  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_DIV   = 3'd1;
  localparam logic [2:0] S_STORE = 3'd2;
  localparam logic [2:0] S_SIGN  = 3'd3;
  localparam logic [2:0] S_RD    = 3'd4;
  localparam logic [2:0] S_EMIT  = 3'd5;
  localparam logic [2:0] S_NUL   = 3'd6;

  logic [2:0] state;
  logic [2:0] state_next;

  // State register.
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Next state and command decode.
  always_comb begin
    state_next = state;
    cmd        = '0;
    unique case (state)
      S_IDLE: begin
        if (start) begin
          if (status.radix_ok) begin
            cmd.load   = 1'b1;
            state_next = S_DIV;
          end else begin
            // A bad radix gives only the terminator, straight from idle.
            cmd.emit_nul = 1'b1;
          end
        end
      end
      S_DIV: begin
        cmd.div_step = 1'b1;
        if (status.div_last) begin
          state_next = S_STORE;
        end
      end
      S_STORE: begin
        cmd.store = 1'b1;
        if (status.q_zero) begin
          state_next = status.neg ? S_SIGN : S_RD;
        end else begin
          state_next = S_DIV;
        end
      end
      S_SIGN: begin
        // The sign beat also covers the first digit read.
        cmd.emit_sign = 1'b1;
        state_next    = S_EMIT;
      end
      S_RD: begin
        state_next = S_EMIT;
      end
      S_EMIT: begin
        cmd.emit_digit = 1'b1;
        if (status.ptr_zero) begin
          state_next = S_NUL;
        end
      end
      S_NUL: begin
        cmd.emit_nul = 1'b1;
        state_next   = S_IDLE;
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  assign busy = (state != S_IDLE);

endmodule

### rtl/sitar_datapath.sv
// Datapath: magnitude, iterative divider, digit memory and output registers.
module sitar_datapath
  import sitar_pkg::*;
#(
  parameter int VALUE_BITS = 32
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic signed [VALUE_BITS-1:0] number,
  input  logic [DIGIT_BITS-1:0]        radix,
  input  cmd_t                         cmd,
  output status_t                      status,
  output logic [7:0]                   text_char,
  output logic                         is_last,
  output logic                         char_valid
);

  localparam int NSTEP    = (VALUE_BITS + BITS_PER_STEP - 1) / BITS_PER_STEP;
  localparam int PAD_BITS = NSTEP * BITS_PER_STEP;
  localparam int STEP_W   = $clog2(NSTEP);
  localparam int IDX_W    = $clog2(VALUE_BITS);
  localparam int CNT_W    = $clog2(VALUE_BITS + 1);

  logic [VALUE_BITS-1:0] raw;
  logic [VALUE_BITS-1:0] mag;
  logic [PAD_BITS-1:0]   quot;
  logic [DIGIT_BITS-1:0] rem;
  logic [STEP_W-1:0]     step;
  logic                  neg;
  logic [CNT_W-1:0]      count;
  logic [IDX_W-1:0]      ptr;
  logic [IDX_W-1:0]      ptr_next;
  logic [DIGIT_BITS-1:0] rd_data;
  logic [PAD_BITS-1:0]   div_quot;
  logic [DIGIT_BITS-1:0] div_rem;
  logic [DIGIT_BITS-1:0] digit_mem [VALUE_BITS];

  // Magnitude of the two's complement input; the most negative value maps exactly.
  assign raw = $unsigned(number);
  assign mag = raw[VALUE_BITS-1] ? (~raw + {{(VALUE_BITS-1){1'b0}}, 1'b1}) : raw;

  // Restoring division, BITS_PER_STEP quotient bits per cycle, quotient shifted in place.
  always_comb begin
    logic [DIGIT_BITS:0] r_w;
    logic [PAD_BITS-1:0] q_w;
    r_w = {1'b0, rem};
    q_w = quot;
    for (int k = 0; k < BITS_PER_STEP; k++) begin
      r_w = {r_w[DIGIT_BITS-1:0], q_w[PAD_BITS-1]};
      q_w = {q_w[PAD_BITS-2:0], 1'b0};
      if (r_w >= {1'b0, radix}) begin
        r_w    = r_w - {1'b0, radix};
        q_w[0] = 1'b1;
      end
    end
    div_quot = q_w;
    div_rem  = r_w[DIGIT_BITS-1:0];
  end

  // Division state: running quotient, remainder and step counter.
  always_ff @(posedge clk) begin
    if (rst) begin
      quot  <= '0;
      rem   <= '0;
      step  <= '0;
      neg   <= 1'b0;
      count <= '0;
    end else begin
      if (cmd.load) begin
        quot  <= PAD_BITS'(mag);
        rem   <= '0;
        step  <= '0;
        neg   <= raw[VALUE_BITS-1];
        count <= '0;
      end else if (cmd.div_step) begin
        quot <= div_quot;
        rem  <= div_rem;
        step <= step + 1'b1;
      end else if (cmd.store) begin
        rem   <= '0;
        step  <= '0;
        count <= count + 1'b1;
      end
    end
  end

  // Read pointer walks the stored digits from the most significant down.
  always_comb begin
    priority if (cmd.store) begin
      ptr_next = count[IDX_W-1:0];
    end else if (cmd.emit_digit) begin
      ptr_next = ptr - 1'b1;
    end else begin
      ptr_next = ptr;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      ptr <= '0;
    end else begin
      ptr <= ptr_next;
    end
  end

  // Digit memory: one write port, one registered read port.
  always_ff @(posedge clk) begin
    if (cmd.store) begin
      digit_mem[count[IDX_W-1:0]] <= rem;
    end
    rd_data <= digit_mem[ptr_next];
  end

  // Output beat registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      char_valid <= 1'b0;
    end else begin
      char_valid <= cmd.emit_sign | cmd.emit_digit | cmd.emit_nul;
    end
  end

  // Character and last flag hold their value between beats.
  always_ff @(posedge clk) begin
    if (cmd.emit_sign) begin
      text_char <= MINUS_CHAR;
      is_last   <= 1'b0;
    end else if (cmd.emit_digit) begin
      text_char <= digit_char(rd_data);
      is_last   <= 1'b0;
    end else if (cmd.emit_nul) begin
      text_char <= NUL_CHAR;
      is_last   <= 1'b1;
    end
  end

  // Status back to the controller.
  assign status.radix_ok = (radix >= RADIX_MIN) && (radix <= RADIX_MAX);
  assign status.div_last = (step == STEP_W'(NSTEP - 1));
  assign status.q_zero   = (quot == '0);
  assign status.neg      = neg;
  assign status.ptr_zero = (ptr == '0);

endmodule
